/* hdl/tascs_pkg.sv */
// Package: types, codes and arithmetic helpers for the skew correction block.
`default_nettype none
package tascs_pkg;

	localparam int MAX_SAMPLES_DEF = 1024;
	localparam int SUM_W   = 48;
	localparam int SUMSQ_W = 64;
	localparam int PROD_W  = 66;
	localparam int OPND_W  = 33;
	localparam int DVD_W   = 65;
	localparam int REM_W   = 35;
	localparam int DIV_STEPS  = 65;
	localparam int ROOT_STEPS = 32;
	localparam int IT_W = 7;

	localparam logic [1:0] REG_X_DRAG = 2'd0;
	localparam logic [1:0] REG_X_LIFT = 2'd1;
	localparam logic [1:0] REG_Y_X    = 2'd2;
	localparam logic [1:0] REG_Y_DRAG = 2'd3;

	localparam logic KIND_SAMPLE  = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE, ST_MUL, ST_POST, ST_ROOT, ST_SAMPLE_OUT, ST_DIV, ST_DIV_POST, ST_SUM_OUT
	} state_t;

	typedef enum logic [2:0] {
		OP_XA, OP_XB, OP_YC, OP_YD, OP_XX, OP_YY, OP_NN, OP_MM
	} op_t;

	typedef enum logic [1:0] {
		DV_X, DV_Y, DV_NET, DV_NSQ
	} dv_t;

	function automatic logic [31:0] sat32(input logic signed [PROD_W-1:0] v);
		logic [31:0] r;
		if (v > 66'sd2147483647)
			r = 32'h7FFF_FFFF;
		else if (v < -66'sd2147483648)
			r = 32'h8000_0000;
		else
			r = v[31:0];
		return r;
	endfunction

	function automatic logic [31:0] usat32(input logic [DVD_W-1:0] v);
		return (|v[DVD_W-1:32]) ? 32'hFFFF_FFFF : v[31:0];
	endfunction

endpackage
`default_nettype wire

/* hdl/two_axis_skew_correct_stats_core.sv */
// Top level: skew correction, magnitude and run statistics on one shared datapath.
// A sample result takes seven multiplies on the shared 33x33 multiplier and a 32-step
// square root, then waits in the output state until the output slot is free; the next
// beat is taken only once that result has been put on the output.
// A last beat adds four 65-step divisions, one multiply and a 32-step root.
// One input beat is in work at a time. Reset loads the coefficient reset values, clears the sums.
`default_nettype none
module two_axis_skew_correct_stats_core #(
	parameter int MAX_SAMPLES = tascs_pkg::MAX_SAMPLES_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [3:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// drag_sample[15:0], lift_sample[31:16], angle_tag[47:32]
	input  wire logic [47:0]  s_axis_tdata,
	input  wire logic         s_axis_tlast,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// tag_out[15:0], value_x[47:16], value_y[79:48], value_net[111:80],
	// net_variance[143:112], net_deviation[175:144]
	output logic [175:0]      m_axis_tdata,
	// result_kind
	output logic              m_axis_tuser,
	output logic              m_axis_tlast
);
	import tascs_pkg::*;

	localparam int CW = $clog2(MAX_SAMPLES + 1);

	state_t state_q, state_d;
	op_t    op_q;
	dv_t    dv_q;

	logic signed [31:0] coef_a_q, coef_b_q, coef_c_q, coef_d_q;
	logic [15:0] drag_q, lift_q, tag_q;
	logic        last_q;

	logic signed [PROD_W-1:0] p_q, acc_q;
	logic [31:0] x_q, y_q, net_q, mx_q, my_q, mn_q, var_q;
	logic [DVD_W-1:0] msq_q;
	logic        neg_q;

	logic [CW-1:0]        cnt_q;
	logic [SUM_W-1:0]     sum_x_q, sum_y_q, sum_net_q;
	logic [SUMSQ_W-1:0]   sum_nsq_q;

	logic [DVD_W-1:0]  src_q, quo_q;
	logic [REM_W-1:0]  rem_q;
	logic [IT_W-1:0]   it_q;

	logic m_valid_q;
	logic slot_free;
	logic emit;

	// shared multiplier operands
	logic signed [OPND_W-1:0] opa, opb;
	logic signed [PROD_W-1:0] prod;

	always_comb begin
		case (op_q)
			OP_XA: begin opa = {coef_a_q[31], coef_a_q}; opb = 33'($signed(drag_q)); end
			OP_XB: begin opa = {coef_b_q[31], coef_b_q}; opb = 33'($signed(lift_q)); end
			OP_YC: begin opa = {coef_c_q[31], coef_c_q}; opb = {x_q[31], x_q}; end
			OP_YD: begin opa = {coef_d_q[31], coef_d_q}; opb = 33'($signed(drag_q)); end
			OP_XX: begin opa = {x_q[31], x_q}; opb = {x_q[31], x_q}; end
			OP_YY: begin opa = {y_q[31], y_q}; opb = {y_q[31], y_q}; end
			OP_NN: begin opa = {1'b0, net_q}; opb = {1'b0, net_q}; end
			OP_MM: begin opa = {1'b0, mn_q}; opb = {1'b0, mn_q}; end
			default: begin opa = '0; opb = '0; end
		endcase
	end
	assign prod = opa * opb;

	// shared shift/compare/subtract step: root (two bits a step) or divide (one bit)
	logic              root_mode;
	logic [REM_W-1:0]  rem_sh, trial, rem_n;
	logic              ge;
	assign root_mode = (state_q == ST_ROOT);
	always_comb begin
		if (root_mode) begin
			rem_sh = {rem_q[REM_W-3:0], src_q[63:62]};
			trial  = {1'b0, quo_q[31:0], 2'b01};
		end else begin
			rem_sh = {rem_q[REM_W-2:0], src_q[DVD_W-1]};
			trial  = REM_W'(cnt_q);
		end
		ge    = (rem_sh >= trial);
		rem_n = ge ? rem_sh - trial : rem_sh;
	end

	// post-processing of products
	logic signed [PROD_W-1:0] tx, ty, tyy;
	logic [DVD_W-1:0] nsq_r, mn2, vdiff;
	logic [SUM_W-1:0] v48;
	always_comb begin
		tx    = (acc_q + p_q + PROD_W'(1 << 13)) >>> 14;
		ty    = (acc_q + (p_q <<< 2) + PROD_W'(1 << 15)) >>> 16;
		tyy   = acc_q + p_q;
		nsq_r = DVD_W'((p_q[DVD_W-1:0] + DVD_W'(1 << 15)) >> 16);
		mn2   = nsq_r;
		vdiff = (msq_q > mn2) ? msq_q - mn2 : '0;
		v48   = (|vdiff[DVD_W-1:SUM_W]) ? {SUM_W{1'b1}} : vdiff[SUM_W-1:0];
	end

	// division setup
	logic [SUM_W-1:0] smag;
	logic             sneg;
	logic [DVD_W-1:0] dividend;
	logic [CW-1:0]    half_n;
	assign half_n = cnt_q >> 1;
	always_comb begin
		sneg = 1'b0;
		smag = '0;
		case (dv_q)
			DV_X: begin sneg = sum_x_q[SUM_W-1]; smag = sneg ? -sum_x_q : sum_x_q; end
			DV_Y: begin sneg = sum_y_q[SUM_W-1]; smag = sneg ? -sum_y_q : sum_y_q; end
			DV_NET: smag = sum_net_q;
			default: smag = '0;
		endcase
		if (dv_q == DV_NSQ)
			dividend = DVD_W'(sum_nsq_q) + DVD_W'(half_n);
		else
			dividend = DVD_W'(smag) + DVD_W'(half_n);
	end

	logic signed [PROD_W-1:0] sq_div;
	assign sq_div = neg_q ? -$signed(PROD_W'(quo_q)) : $signed(PROD_W'(quo_q));

	assign slot_free = !m_valid_q || m_axis_tready;
	assign emit = slot_free && (state_q == ST_SAMPLE_OUT || state_q == ST_SUM_OUT);
	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign pready = 1'b1;

	always_comb begin
		case (paddr[3:2])
			REG_X_DRAG: prdata = coef_a_q;
			REG_X_LIFT: prdata = coef_b_q;
			REG_Y_X:    prdata = coef_c_q;
			REG_Y_DRAG: prdata = coef_d_q;
			default:    prdata = '0;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:       if (s_axis_tvalid) state_d = ST_MUL;
			ST_MUL:        state_d = ST_POST;
			ST_POST: begin
				case (op_q)
					OP_YY, OP_MM: state_d = ST_ROOT;
					OP_NN:        state_d = ST_SAMPLE_OUT;
					default:      state_d = ST_MUL;
				endcase
			end
			ST_ROOT: begin
				if (it_q == IT_W'(ROOT_STEPS - 1))
					state_d = (op_q == OP_MM) ? ST_SUM_OUT : ST_MUL;
			end
			ST_SAMPLE_OUT: if (slot_free) state_d = last_q ? ST_DIV : ST_IDLE;
			ST_DIV:        if (it_q == IT_W'(DIV_STEPS)) state_d = ST_DIV_POST;
			ST_DIV_POST:   state_d = (dv_q == DV_NSQ) ? ST_MUL : ST_DIV;
			ST_SUM_OUT:    if (slot_free) state_d = ST_IDLE;
			default:       state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_a_q  <= 32'sd65536;
			coef_b_q  <= '0;
			coef_c_q  <= '0;
			coef_d_q  <= '0;
			op_q      <= OP_XA;
			dv_q      <= DV_X;
			cnt_q     <= '0;
			sum_x_q   <= '0;
			sum_y_q   <= '0;
			sum_net_q <= '0;
			sum_nsq_q <= '0;
			m_valid_q <= 1'b0;
			it_q      <= '0;
		end else begin
			if (psel && penable && pwrite) begin
				case (paddr[3:2])
					REG_X_DRAG: coef_a_q <= pwdata;
					REG_X_LIFT: coef_b_q <= pwdata;
					REG_Y_X:    coef_c_q <= pwdata;
					REG_Y_DRAG: coef_d_q <= pwdata;
					default: ;
				endcase
			end
			if (emit)
				m_valid_q <= 1'b1;
			else if (m_valid_q && m_axis_tready)
				m_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						drag_q <= s_axis_tdata[15:0];
						lift_q <= s_axis_tdata[31:16];
						tag_q  <= s_axis_tdata[47:32];
						last_q <= s_axis_tlast;
						op_q   <= OP_XA;
					end
				end
				ST_MUL: p_q <= prod;
				ST_POST: begin
					it_q  <= '0;
					rem_q <= '0;
					quo_q <= '0;
					case (op_q)
						OP_XA: begin acc_q <= p_q; op_q <= OP_XB; end
						OP_XB: begin x_q <= sat32(tx); op_q <= OP_YC; end
						OP_YC: begin acc_q <= p_q; op_q <= OP_YD; end
						OP_YD: begin y_q <= sat32(ty); op_q <= OP_XX; end
						OP_XX: begin acc_q <= p_q; op_q <= OP_YY; end
						OP_YY: src_q <= {1'b0, tyy[63:0]};
						OP_NN: begin
							if (cnt_q < CW'(MAX_SAMPLES)) begin
								cnt_q     <= cnt_q + 1'b1;
								sum_x_q   <= sum_x_q + SUM_W'($signed(x_q));
								sum_y_q   <= sum_y_q + SUM_W'($signed(y_q));
								sum_net_q <= sum_net_q + SUM_W'(net_q);
								sum_nsq_q <= sum_nsq_q + nsq_r[SUMSQ_W-1:0];
							end
						end
						OP_MM: begin
							var_q <= usat32(DVD_W'(v48));
							src_q <= {1'b0, v48, 16'b0};
						end
						default: ;
					endcase
				end
				ST_ROOT: begin
					rem_q <= rem_n;
					quo_q <= {quo_q[DVD_W-2:0], ge};
					src_q <= src_q << 2;
					it_q  <= it_q + 1'b1;
					if (it_q == IT_W'(ROOT_STEPS - 1)) begin
						if (op_q == OP_YY) begin
							net_q <= {quo_q[30:0], ge};
							op_q  <= OP_NN;
						end
					end
				end
				ST_SAMPLE_OUT: begin
					if (slot_free) begin
						m_axis_tuser <= KIND_SAMPLE;
						m_axis_tlast <= !last_q;
						m_axis_tdata <= {32'b0, 32'b0, net_q, y_q, x_q, tag_q};
						dv_q  <= DV_X;
						it_q  <= '0;
						rem_q <= '0;
						quo_q <= '0;
					end
				end
				ST_DIV: begin
					if (it_q == '0) begin
						// load dividend; the first step runs on the next cycle
						src_q <= dividend;
						neg_q <= sneg;
						it_q  <= it_q + 1'b1;
					end else if (it_q != IT_W'(DIV_STEPS)) begin
						rem_q <= rem_n;
						quo_q <= {quo_q[DVD_W-2:0], ge};
						src_q <= src_q << 1;
						it_q  <= it_q + 1'b1;
					end else begin
						rem_q <= rem_n;
						quo_q <= {quo_q[DVD_W-2:0], ge};
					end
				end
				ST_DIV_POST: begin
					it_q  <= '0;
					rem_q <= '0;
					quo_q <= '0;
					case (dv_q)
						DV_X:   begin mx_q <= sat32(sq_div); dv_q <= DV_Y; end
						DV_Y:   begin my_q <= sat32(sq_div); dv_q <= DV_NET; end
						DV_NET: begin mn_q <= usat32(quo_q); dv_q <= DV_NSQ; end
						default: begin msq_q <= quo_q; op_q <= OP_MM; end
					endcase
				end
				ST_SUM_OUT: begin
					if (slot_free) begin
						m_axis_tuser <= KIND_SUMMARY;
						m_axis_tlast <= 1'b1;
						m_axis_tdata <= {quo_q[31:0], var_q, mn_q, my_q, mx_q, 16'b0};
						cnt_q     <= '0;
						sum_x_q   <= '0;
						sum_y_q   <= '0;
						sum_net_q <= '0;
						sum_nsq_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

/* bench/tb_two_axis_skew_correct_stats_core.sv */
// Testbench for the skew correction and run statistics block: stream beats in, results checked against a behavioral predictor.
`timescale 1ns / 100ps
`default_nettype none
module tb_two_axis_skew_correct_stats_core;
	import tascs_pkg::*;

	typedef struct packed {
		logic        kind;
		logic [15:0] tag;
		logic [31:0] vx;
		logic [31:0] vy;
		logic [31:0] vnet;
		logic [31:0] var_q;
		logic [31:0] dev_q;
		logic        last;
	} result_t;

	logic         clk;
	logic         arst_n;
	logic         psel, penable, pwrite;
	logic [3:0]   paddr;
	logic [31:0]  pwdata;
	logic [31:0]  prdata;
	logic         pready;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [47:0]  s_axis_tdata;
	logic         s_axis_tlast;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [175:0] m_axis_tdata;
	logic         m_axis_tuser;
	logic         m_axis_tlast;

	two_axis_skew_correct_stats_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	// predictor copy of coefficients and run sums
	logic signed [31:0] coef_a, coef_b, coef_c, coef_d;
	logic [10:0]        run_count;
	logic signed [63:0] run_sum_x, run_sum_y;
	logic [63:0]        run_sum_net, run_sum_nsq;

	result_t expected_results[$];
	int      mismatches;
	int      results_seen;
	int      summaries_seen;
	int      beats_sent;
	bit      idle_enable;

	initial begin
		clk = 1'b0;
		forever begin
			#4 clk = 1'b1;
			#4 clk = 1'b0;
		end
	end

	initial begin
		#50ms;
		$display("Timeout at %0t", $realtime);
		$display("Regression FAIL");
		$finish;
	end

	function automatic logic [63:0] isqrt(input logic [63:0] v);
		logic [63:0] r, b, rem;
		r = 0;
		rem = v;
		b = 64'd1 << 62;
		while (b > rem)
			b = b >> 2;
		while (b != 0) begin
			if (rem >= r + b) begin
				rem = rem - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic logic signed [31:0] clamp_s32(input logic signed [79:0] v);
		if (v > 80'sd2147483647)
			return 32'sh7FFF_FFFF;
		if (v < -80'sd2147483648)
			return 32'sh8000_0000;
		return v[31:0];
	endfunction

	function automatic logic signed [63:0] rounded_mean(input logic signed [63:0] s,
			input logic [63:0] n);
		logic [63:0] mag, q;
		mag = s < 0 ? -s : s;
		q = (mag + n / 2) / n;
		return s < 0 ? -$signed(q) : $signed(q);
	endfunction

	// works out the results of one sample beat and updates the run sums
	task automatic predict_sample(input logic [15:0] drag_raw, input logic [15:0] lift_raw,
			input logic [15:0] tag, input logic fin);
		logic signed [79:0] accx, accy;
		logic signed [31:0] x, y;
		logic [63:0]        sq, net, n, msq, mn2, v;
		logic signed [63:0] mx, my;
		logic [63:0]        mn;
		result_t            r;
		accx = coef_a * $signed(drag_raw) + coef_b * $signed(lift_raw);
		x = clamp_s32((accx + 80'sd8192) >>> 14);
		accy = coef_c * x + coef_d * $signed(drag_raw) * 80'sd4;
		y = clamp_s32((accy + 80'sd32768) >>> 16);
		sq = 64'($signed(64'(x)) * $signed(64'(x))) + 64'($signed(64'(y)) * $signed(64'(y)));
		net = isqrt(sq);
		if (run_count < 11'd1024) begin
			run_count = run_count + 1'b1;
			run_sum_x = run_sum_x + x;
			run_sum_y = run_sum_y + y;
			run_sum_net = run_sum_net + net;
			run_sum_nsq = run_sum_nsq + ((net * net + 64'd32768) >> 16);
		end
		r = '{KIND_SAMPLE, tag, x, y, net[31:0], 32'd0, 32'd0, !fin};
		expected_results.push_back(r);
		if (fin) begin
			n = run_count;
			r = '{KIND_SUMMARY, 16'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1};
			if (n != 0) begin
				mx = rounded_mean(run_sum_x, n);
				my = rounded_mean(run_sum_y, n);
				r.vx = clamp_s32(80'(mx));
				r.vy = clamp_s32(80'(my));
				mn = (run_sum_net + n / 2) / n;
				if (mn > 64'hFFFF_FFFF)
					mn = 64'hFFFF_FFFF;
				r.vnet = mn[31:0];
				msq = (run_sum_nsq + n / 2) / n;
				mn2 = (mn * mn + 64'd32768) >> 16;
				v = msq > mn2 ? msq - mn2 : 64'd0;
				if (v > 64'hFFFF_FFFF_FFFF)
					v = 64'hFFFF_FFFF_FFFF;
				r.var_q = v > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : v[31:0];
				r.dev_q = 32'(isqrt(v << 16));
			end
			expected_results.push_back(r);
			run_count = 0;
			run_sum_x = 0;
			run_sum_y = 0;
			run_sum_net = 0;
			run_sum_nsq = 0;
		end
	endtask

	task automatic idle_burst();
		if (idle_enable && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
	endtask

	// drop tvalid right after the last accepted beat when no beat follows
	task automatic hold_input();
		s_axis_tvalid <= 1'b0;
	endtask

	task automatic send_sample(input logic [15:0] drag_raw, input logic [15:0] lift_raw,
			input logic [15:0] tag, input logic fin);
		idle_burst();
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {tag, lift_raw, drag_raw};
		s_axis_tlast <= fin;
		do
			@(posedge clk);
		while (!s_axis_tready);
		predict_sample(drag_raw, lift_raw, tag, fin);
		beats_sent++;
	endtask

	task automatic drain_results();
		hold_input();
		while (expected_results.size() != 0)
			@(posedge clk);
		// every expected result is back, so no sample beat is still in work
		repeat (400) @(posedge clk);
	endtask

	task automatic write_coef(input logic [1:0] idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_X_DRAG: coef_a = value;
			REG_X_LIFT: coef_b = value;
			REG_Y_X:    coef_c = value;
			default:    coef_d = value;
		endcase
		@(posedge clk);
	endtask

	task automatic set_coefs(input logic [31:0] a, input logic [31:0] b,
			input logic [31:0] c, input logic [31:0] d);
		drain_results();
		write_coef(REG_X_DRAG, a);
		write_coef(REG_X_LIFT, b);
		write_coef(REG_Y_X, c);
		write_coef(REG_Y_DRAG, d);
	endtask

	function automatic logic [15:0] pick_sample();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7FFF;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [31:0] pick_coef();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'd0;
			3, 4: return 32'($signed($urandom_range(0, 262144)) - 131072);
			default: return $urandom;
		endcase
	endfunction

	// extremes of the samples and the tag under the reset coefficients
	task automatic test_reset_coefs();
		send_sample(16'h0000, 16'h0000, 16'h0000, 1'b0);
		send_sample(16'h7FFF, 16'h8000, 16'hFFFF, 1'b0);
		send_sample(16'h8000, 16'h7FFF, 16'h5555, 1'b0);
		send_sample(16'hFFFF, 16'h0001, 16'hAAAA, 1'b1);
		// a run of one sample
		send_sample(16'h4000, 16'hC000, 16'h1234, 1'b1);
	endtask

	// saturation of x and y and the variance clamps with extreme coefficients
	task automatic test_saturation();
		set_coefs(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
		send_sample(16'h7FFF, 16'h8000, 16'h0001, 1'b0);
		send_sample(16'h8000, 16'h7FFF, 16'h0002, 1'b0);
		send_sample(16'h0001, 16'h0000, 16'h0003, 1'b0);
		send_sample(16'h0000, 16'h0000, 16'h0004, 1'b1);
		set_coefs(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
		send_sample(16'h7FFF, 16'h7FFF, 16'hFFFF, 1'b0);
		send_sample(16'h8000, 16'h8000, 16'h0000, 1'b1);
	endtask

	// signed means rounding half away from zero on negative sums
	task automatic test_rounding();
		set_coefs(32'hFFFF_0000, 32'h0000_8000, 32'h0001_0000, 32'hFFFF_FFFF);
		send_sample(16'h0001, 16'h0003, 16'h0100, 1'b0);
		send_sample(16'h0002, 16'hFFFD, 16'h0200, 1'b0);
		send_sample(16'hFFFF, 16'h0000, 16'h0300, 1'b1);
	endtask

	// runs past the accumulator limit: extra samples leave the statistics alone
	task automatic test_full_accumulator();
		set_coefs(32'h0001_0000, 32'h0000_4000, 32'h0000_8000, 32'h0002_0000);
		for (int i = 0; i < 1026; i++)
			send_sample(pick_sample(), pick_sample(), 16'(i), i == 1025);
	endtask

	// random runs of random length under several coefficient settings
	task automatic test_random_runs();
		int left;
		for (int phase = 0; phase < 4; phase++) begin
			set_coefs(pick_coef(), pick_coef(), pick_coef(), pick_coef());
			left = 30;
			while (left > 0) begin
				send_sample(pick_sample(), pick_sample(), 16'($urandom),
					$urandom_range(0, 11) == 0 || left == 1);
				left--;
			end
			if (phase == 2) begin
				// hold the sender until every result is back
				hold_input();
				while (expected_results.size() != 0)
					@(posedge clk);
			end
		end
	endtask

	// result side: ready with random stall bursts
	initial begin
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (idle_enable && $urandom_range(0, 5) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
		end
	end

	// result checker
	always @(posedge clk) begin
		result_t got, exp_r;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = '{m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[47:16],
				m_axis_tdata[79:48], m_axis_tdata[111:80], m_axis_tdata[143:112],
				m_axis_tdata[175:144], m_axis_tlast};
			results_seen++;
			if (got.kind == KIND_SUMMARY)
				summaries_seen++;
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t unexpected result %p", $realtime, got);
			end else begin
				exp_r = expected_results.pop_front();
				if (got !== exp_r) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t mismatch: expected %p actual %p", $realtime, exp_r, got);
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tlast = 1'b0;
		coef_a = 32'sd65536;
		coef_b = 0;
		coef_c = 0;
		coef_d = 0;
		run_count = 0;
		run_sum_x = 0;
		run_sum_y = 0;
		run_sum_net = 0;
		run_sum_nsq = 0;
		mismatches = 0;
		results_seen = 0;
		summaries_seen = 0;
		beats_sent = 0;
		idle_enable = 1'b1;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_coefs();
		test_saturation();
		test_rounding();
		test_random_runs();
		test_full_accumulator();
		idle_enable = 1'b0;
		set_coefs(pick_coef(), pick_coef(), pick_coef(), pick_coef());
		for (int i = 0; i < 20; i++)
			send_sample(pick_sample(), pick_sample(), 16'($urandom), i % 5 == 4);
		drain_results();

		$display("Sent %0d sample beats over several coefficient settings, checked %0d results",
			beats_sent, results_seen);
		$display("including %0d run summaries, saturation and a run past the sample limit",
			summaries_seen);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatches,
				expected_results.size());
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule
`default_nettype wire

/* two_axis_skew_correct_stats_core.f */
hdl/tascs_pkg.sv
hdl/two_axis_skew_correct_stats_core.sv
bench/tb_two_axis_skew_correct_stats_core.sv
